@@ hw/rtl/mbd_pkg.sv @@
// mbd_pkg: sizes, register codes, state encoding and channel arithmetic
// for the mipmap box downsampler; no dependencies
`timescale 1ns / 1ps

package mbd_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MAX_LEVELS = 13;

    localparam int COORD_W = $clog2(MAX_DIM);        // 12
    localparam int DIM_W   = COORD_W + 1;            // 13, holds MAX_DIM itself
    localparam int LVL_W   = $clog2(MAX_LEVELS);     // 4
    localparam int ROW_AW  = $clog2(MAX_DIM);
    localparam int PIX_W   = 32;
    localparam int SUM_W   = 36;                     // four 9-bit pair sums
    localparam int IDX_W   = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_LEVEL_COUNT  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_AVG
    } t_state;

    // clamped configuration as seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [LVL_W-1:0] levels;
    } t_cfg;

    // per-channel sum of two rgba8 pixels, 9 bits per channel
    function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int c = 0; c < 4; c++) begin
            s[9*c +: 9] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
        end
        return s;
    endfunction

    // add two rows of pair sums and divide by four, truncating
    function automatic logic [PIX_W-1:0] quad_avg(input logic [SUM_W-1:0] top,
                                                   input logic [SUM_W-1:0] bot);
        logic [PIX_W-1:0] p;
        logic [9:0]       v;
        p = '0;
        for (int c = 0; c < 4; c++) begin
            v = {1'b0, top[9*c +: 9]} + {1'b0, bot[9*c +: 9]};
            p[8*c +: 8] = v[9:2];
        end
        return p;
    endfunction

endpackage

@@ hw/rtl/mbd_intf.sv @@
// channel interfaces of the mipmap box downsampler: config writes,
// base pixels in, mip results out; depends on mbd_pkg
`timescale 1ns / 1ps

interface mbd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mbd_pkg::IDX_W-1:0]   index;
    logic [mbd_pkg::DIM_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface mbd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;

    modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface mbd_res_if;
    logic                          valid;
    logic                          ready;
    logic [mbd_pkg::LVL_W-1:0]     mip_level;
    logic [mbd_pkg::COORD_W-1:0]   pix_x;
    logic [mbd_pkg::COORD_W-1:0]   pix_y;
    logic [7:0]                    out_red;
    logic [7:0]                    out_green;
    logic [7:0]                    out_blue;
    logic [7:0]                    out_alpha;
    logic                          run_last;

    modport source (output valid, mip_level, pix_x, pix_y, out_red, out_green,
                    out_blue, out_alpha, run_last, input ready);
    modport sink   (input valid, mip_level, pix_x, pix_y, out_red, out_green,
                    out_blue, out_alpha, run_last, output ready);
endinterface

@@ hw/rtl/mipmap_box_downsampler.sv @@
// mipmap_box_downsampler: top level, sequencer and mip cascade datapath
// depends on mbd_pkg, mbd_intf, mbd_ram and mbd_cfg
`timescale 1ns / 1ps

// usage
// - i_cfg: register writes (0 image_width, 1 image_height, 2 level_count),
//   always ready; write only while the block is idle
// - i_pix: base-level rgba8 pixels in raster order, one transfer per pixel
// - o_res: every pixel passes out as level 0, followed by each higher
//   level pixel it completes, lowest level first; run_last marks the last
//   result of that input pixel
// - timing: a pixel is taken in idle, its level 0 result is offered the
// next cycle; each higher level takes an average state followed by an
// emit state; this emit/average loop is set by the row pair-sum ram,
// whose read data is registered
// - i_pix.ready is low until every result of the current pixel has been
//   transferred; a stalled o_res simply holds the current result
// - reset returns config to 256x256 with 9 levels and the raster position
//   to (0,0); the pending-pixel and pair-sum rams are not cleared and are
//   always written before read by a proper raster stream
// - a full image wraps the position back to (0,0); if config changed so
//   that the position lies outside the image, it restarts at (0,0)

module mipmap_box_downsampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbd_cfg_if.sink     i_cfg,
    mbd_pix_if.sink     i_pix,
    mbd_res_if.source   o_res
);

    localparam int CW = mbd_pkg::COORD_W;
    localparam int DW = mbd_pkg::DIM_W;
    localparam int LW = mbd_pkg::LVL_W;

    mbd_pkg::t_cfg   cfg;
    mbd_pkg::t_state r_state, n_state;

    // raster position of the next base pixel
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;

    // the pixel currently in flight through the cascade
    logic [CW-1:0]             r_x, n_x;
    logic [CW-1:0]             r_y, n_y;
    logic [LW-1:0]             r_lvl, n_lvl;
    logic [mbd_pkg::PIX_W-1:0] r_pix, n_pix;
    logic [mbd_pkg::SUM_W-1:0] r_hs, n_hs;

    logic pix_xfer;
    logic res_xfer;

    // level geometry
    logic [DW-1:0]             lvl_w, lvl_h;
    logic [CW-1:0]             nx, ny;
    logic                      fits, lvl_ok, step, cont;
    logic                      wr_pend, wr_row;
    logic [DW-1:0]             row_off;
    logic [mbd_pkg::ROW_AW-1:0] row_idx;

    // raster bookkeeping
    logic          restart;
    logic [CW-1:0] start_col, start_row;
    logic [DW-1:0] col_inc, row_inc;

    // ram ports
    logic                      pend_we, row_we;
    logic [mbd_pkg::PIX_W-1:0] pend_rdata;
    logic [mbd_pkg::SUM_W-1:0] row_rdata;
    logic [mbd_pkg::SUM_W-1:0] hs;
    logic [mbd_pkg::PIX_W-1:0] avg;

    mbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign pix_xfer = i_pix.valid && i_pix.ready;
    assign res_xfer = o_res.valid && o_res.ready;

    // size of the current level and where its parent pixel would land
    assign lvl_w  = cfg.width >> r_lvl;
    assign lvl_h  = cfg.height >> r_lvl;
    assign nx     = r_x >> 1;
    assign ny     = r_y >> 1;
    assign fits   = ({1'b0, nx} < (lvl_w >> 1)) && ({1'b0, ny} < (lvl_h >> 1));
    assign lvl_ok = ({1'b0, r_lvl} + (LW+1)'(1)) < {1'b0, cfg.levels};
    assign step   = lvl_ok && fits;

    // odd column of an odd row closes a 2x2 block: go up one level
    assign cont    = step && r_x[0] && r_y[0];
    // even column: park the pixel until its right neighbor shows up
    assign wr_pend = step && !r_x[0];
    // odd column of an even row: store the top pair sum for the next row
    assign wr_row  = step && r_x[0] && !r_y[0];

    // each level owns a region of the pair-sum ram, halving per level
    assign row_off = DW'(mbd_pkg::MAX_DIM) - (DW'(mbd_pkg::MAX_DIM) >> r_lvl);
    assign row_idx = mbd_pkg::ROW_AW'(row_off + {1'b0, nx});

    // pending even pixel per level; read address is the next level n_lvl so
    // the registered read data lines up with r_lvl
    mbd_ram #(
        .DEPTH (mbd_pkg::MAX_LEVELS),
        .WIDTH (mbd_pkg::PIX_W)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (r_lvl),
        .i_wdata (r_pix),
        .i_raddr (n_lvl),
        .o_rdata (pend_rdata)
    );

    // top-row pair sums of every level; read during emit, used in average
    mbd_ram #(
        .DEPTH (mbd_pkg::MAX_DIM),
        .WIDTH (mbd_pkg::SUM_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_idx),
        .i_wdata (hs),
        .i_raddr (row_idx),
        .o_rdata (row_rdata)
    );

    assign hs  = mbd_pkg::pair_sum(pend_rdata, r_pix);
    assign avg = mbd_pkg::quad_avg(row_rdata, r_hs);

    // raster position, restarted when config shrank under it
    assign restart   = ({1'b0, r_col} >= cfg.width) || ({1'b0, r_row} >= cfg.height);
    assign start_col = restart ? '0 : r_col;
    assign start_row = restart ? '0 : r_row;
    assign col_inc   = {1'b0, start_col} + DW'(1);
    assign row_inc   = {1'b0, start_row} + DW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbd_pkg::S_IDLE: if (pix_xfer) n_state = mbd_pkg::S_EMIT;
            mbd_pkg::S_EMIT: begin
                if (res_xfer) n_state = cont ? mbd_pkg::S_AVG : mbd_pkg::S_IDLE;
            end
            mbd_pkg::S_AVG:  n_state = mbd_pkg::S_EMIT;
            default:         n_state = mbd_pkg::S_IDLE;
        endcase
    end

    // state outputs: handshakes and ram writes
    always_comb begin
        i_pix.ready = 1'b0;
        o_res.valid = 1'b0;
        pend_we     = 1'b0;
        row_we      = 1'b0;
        unique case (r_state)
            mbd_pkg::S_IDLE: i_pix.ready = 1'b1;
            mbd_pkg::S_EMIT: begin
                o_res.valid = 1'b1;
                pend_we     = res_xfer && wr_pend;
                row_we      = res_xfer && wr_row;
            end
            mbd_pkg::S_AVG: ;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_x   = r_x;
        n_y   = r_y;
        n_lvl = r_lvl;
        n_pix = r_pix;
        n_hs  = r_hs;
        unique case (r_state)
            mbd_pkg::S_IDLE: begin
                if (pix_xfer) begin
                    n_x   = start_col;
                    n_y   = start_row;
                    n_lvl = '0;
                    n_pix = {i_pix.in_alpha, i_pix.in_blue, i_pix.in_green, i_pix.in_red};
                    if (col_inc >= cfg.width) begin
                        n_col = '0;
                        n_row = (row_inc >= cfg.height) ? '0 : row_inc[CW-1:0];
                    end else begin
                        n_col = col_inc[CW-1:0];
                        n_row = start_row;
                    end
                end
            end
            mbd_pkg::S_EMIT: begin
                if (res_xfer && cont) n_hs = hs;
            end
            mbd_pkg::S_AVG: begin
                n_pix = avg;
                n_lvl = r_lvl + LW'(1);
                n_x   = nx;
                n_y   = ny;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbd_pkg::S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_lvl   <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_pix <= n_pix;
        r_hs  <= n_hs;
    end

    // result payload straight from the cascade registers
    assign o_res.mip_level = r_lvl;
    assign o_res.pix_x     = r_x;
    assign o_res.pix_y     = r_y;
    assign o_res.out_red   = r_pix[7:0];
    assign o_res.out_green = r_pix[15:8];
    assign o_res.out_blue  = r_pix[23:16];
    assign o_res.out_alpha = r_pix[31:24];
    assign o_res.run_last  = !cont;

endmodule

@@ hw/rtl/mbd_ram.sv @@
// mbd_ram: generic single-write, single-read synchronous ram, registered
// read data; no dependencies
`timescale 1ns / 1ps

module mbd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/mbd_cfg.sv @@
// mbd_cfg: configuration registers with range clamping
// depends on mbd_pkg and mbd_cfg_if
`timescale 1ns / 1ps

module mbd_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mbd_cfg_if.sink              i_cfg,
    output mbd_pkg::t_cfg        o_cfg
);

    logic [mbd_pkg::DIM_W-1:0] r_width;
    logic [mbd_pkg::DIM_W-1:0] r_height;
    logic [mbd_pkg::LVL_W-1:0] r_levels;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mbd_pkg::DIM_W'(256);
            r_height <= mbd_pkg::DIM_W'(256);
            r_levels <= mbd_pkg::LVL_W'(9);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (mbd_pkg::t_reg_idx'(i_cfg.index))
                mbd_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg.data;
                mbd_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg.data;
                mbd_pkg::REG_LEVEL_COUNT:  r_levels <= i_cfg.data[mbd_pkg::LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to 1..MAX_DIM and 1..MAX_LEVELS
    always_comb begin
        o_cfg.width  = r_width;
        o_cfg.height = r_height;
        o_cfg.levels = r_levels;
        if (r_width == '0) o_cfg.width = mbd_pkg::DIM_W'(1);
        else if (r_width > mbd_pkg::DIM_W'(mbd_pkg::MAX_DIM))
            o_cfg.width = mbd_pkg::DIM_W'(mbd_pkg::MAX_DIM);
        if (r_height == '0) o_cfg.height = mbd_pkg::DIM_W'(1);
        else if (r_height > mbd_pkg::DIM_W'(mbd_pkg::MAX_DIM))
            o_cfg.height = mbd_pkg::DIM_W'(mbd_pkg::MAX_DIM);
        if (r_levels == '0) o_cfg.levels = mbd_pkg::LVL_W'(1);
        else if (r_levels > mbd_pkg::LVL_W'(mbd_pkg::MAX_LEVELS))
            o_cfg.levels = mbd_pkg::LVL_W'(mbd_pkg::MAX_LEVELS);
    end

endmodule
